// ===== hw/rtl/bmt_pkg.sv =====
// ----------------------------------------------------------------------------
// bmt_pkg: shared types and constants for the breakpoint match table
// Table geometry, command codes, and the packed layout of one bucket row.
// ----------------------------------------------------------------------------
package bmt_pkg;

  // Table geometry. BUCKETS must be a power of two, because the bucket is
  // taken from the low address bits.
  localparam int BUCKETS = 64;
  localparam int WAYS    = 4;

  localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int FILL_W = $clog2(WAYS + 1);

  localparam int ADDR_W = 32;
  localparam int TAG_W  = 32;
  localparam int HND_W  = 16;
  localparam int SLOT_W = 8;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CHECK  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TAG_W-1:0]  pid;
    logic [TAG_W-1:0]  stk;
    logic [HND_W-1:0]  hnd;
  } slot_t;

  // One bucket: all of its slots and its count of allocated ways.
  typedef struct packed {
    slot_t [WAYS-1:0]  slots;
    logic [FILL_W-1:0] fill;
  } row_t;

  // Outcome of one lookup, passed from the match logic to the controller.
  typedef struct packed {
    logic             ok;
    logic [HND_W-1:0] handler;
    logic [WAY_W-1:0] way;
    logic             wr_en;
  } match_t;

endpackage

// ===== hw/rtl/breakpoint_match_table.sv =====
// ----------------------------------------------------------------------------
// breakpoint_match_table: hashed breakpoint table with add, remove and check
// Flow: a request beat taken in IDLE starts the read of its bucket row; in LOOK
// the row is compared, written back and the result loaded into the output
// register. No new request is taken until that read-modify-write is through.
// Reset: synchronous, clears control state and marks every bucket row empty.
// ----------------------------------------------------------------------------
module breakpoint_match_table
  import bmt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        cmd,
  input  logic [ADDR_W-1:0] address,
  input  logic [TAG_W-1:0]  process_id,
  input  logic [TAG_W-1:0]  stack_tag,
  input  logic [HND_W-1:0]  handler_tag,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              ok,
  output logic [HND_W-1:0]  hit_handler,
  output logic [SLOT_W-1:0] slot_index
);

  // The controller has two states. In IDLE a request beat is taken and its
  // bucket row is read from memory. In LOOK the row has arrived, every allocated
  // way is compared at once, the updated row is written back and the result is
  // loaded into the output register, provided that register is free.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_t;

  state_t            state;
  state_t            state_next;
  logic              in_fire;
  logic              finish;

  // Request held for the lookup cycle.
  logic [1:0]        cmd_q;
  logic [ADDR_W-1:0] addr_q;
  logic [TAG_W-1:0]  pid_q;
  logic [TAG_W-1:0]  stk_q;
  logic [HND_W-1:0]  hnd_q;
  logic [BKT_W-1:0]  bucket_q;

  row_t              rd_row;
  row_t              row_next;
  match_t            result;
  logic [31:0]       slot_full;

  // A request is only taken in IDLE and never while reset is held. Because
  // the write-back of one request always lands before the next read is
  // issued, no forwarding is needed.
  assign in_stall = rst || (state != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;

  // The lookup may complete once the output register is empty or is being
  // emptied in this cycle; this is what lets a new request be taken while a
  // result is still waiting downstream.
  assign finish = (state == ST_LOOK) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q    <= cmd;
      addr_q   <= address;
      pid_q    <= process_id;
      stk_q    <= stack_tag;
      hnd_q    <= handler_tag;
      bucket_q <= address[BKT_W-1:0];
    end
  end

  // The bucket is the address modulo the bucket count, which for a power of
  // two count is just the low address bits.
  bmt_row_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire),
    .rd_addr (address[BKT_W-1:0]),
    .rd_row  (rd_row),
    .wr_en   (finish && result.wr_en),
    .wr_addr (bucket_q),
    .wr_row  (row_next)
  );

  bmt_match u_match (
    .cmd         (cmd_q),
    .address     (addr_q),
    .process_id  (pid_q),
    .stack_tag   (stk_q),
    .handler_tag (hnd_q),
    .row         (rd_row),
    .result      (result),
    .row_next    (row_next)
  );

  // Slot number of the touched way, truncated to the port width. A miss
  // reports slot zero.
  assign slot_full = result.ok ? (32'(bucket_q) * 32'(WAYS) + 32'(result.way)) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      ok          <= result.ok;
      hit_handler <= result.handler;
      slot_index  <= slot_full[SLOT_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/bmt_row_ram.sv =====
// ----------------------------------------------------------------------------
// bmt_row_ram: bucket row memory
// One row per bucket, registered read; rows never written since
// reset read as all zero through a per-row valid bit.
// ----------------------------------------------------------------------------
module bmt_row_ram
  import bmt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [BKT_W-1:0] rd_addr,
  output row_t             rd_row,
  input  logic             wr_en,
  input  logic [BKT_W-1:0] wr_addr,
  input  row_t             wr_row
);

  row_t               mem [BUCKETS];
  logic [BUCKETS-1:0] row_valid;
  row_t               rd_q;
  logic               rd_live;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_live   <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_live <= row_valid[rd_addr];
      end
    end
  end

  assign rd_row = rd_live ? rd_q : '0;

endmodule

// ===== hw/rtl/bmt_match.sv =====
// ----------------------------------------------------------------------------
// bmt_match: bucket row compare and update
// Compares the request against every allocated way of one row in parallel and forms
// the outcome and the row to write back.
// ----------------------------------------------------------------------------
module bmt_match
  import bmt_pkg::*;
(
  input  logic [1:0]        cmd,
  input  logic [ADDR_W-1:0] address,
  input  logic [TAG_W-1:0]  process_id,
  input  logic [TAG_W-1:0]  stack_tag,
  input  logic [HND_W-1:0]  handler_tag,
  input  row_t              row,
  output match_t            result,
  output row_t              row_next
);

  logic [FILL_W-1:0] fill;
  logic              free_hit;
  logic [WAY_W-1:0]  free_way;
  logic              exact_hit;
  logic [WAY_W-1:0]  exact_way;
  logic              check_hit;
  logic [WAY_W-1:0]  check_way;
  slot_t             new_slot;

  assign fill = (row.fill > FILL_W'(WAYS)) ? FILL_W'(WAYS) : row.fill;

  // Later ways override earlier ones, so the highest-numbered live way wins.
  always_comb begin
    free_hit  = 1'b0;
    free_way  = '0;
    exact_hit = 1'b0;
    exact_way = '0;
    check_hit = 1'b0;
    check_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (FILL_W'(w) < fill) begin
        if (row.slots[w].addr == '0) begin
          free_hit = 1'b1;
          free_way = WAY_W'(w);
        end
        if (row.slots[w].addr == address && row.slots[w].pid == process_id &&
            row.slots[w].stk == stack_tag) begin
          exact_hit = 1'b1;
          exact_way = WAY_W'(w);
        end
        if (row.slots[w].addr == address &&
            (row.slots[w].pid == '0 || row.slots[w].pid == process_id) &&
            (row.slots[w].stk == '0 || row.slots[w].stk == stack_tag)) begin
          check_hit = 1'b1;
          check_way = WAY_W'(w);
        end
      end
    end
  end

  assign new_slot = '{addr: address, pid: process_id, stk: stack_tag, hnd: handler_tag};

  always_comb begin
    result   = '0;
    row_next = row;
    case (cmd)
      CMD_ADD: begin
        if (free_hit) begin
          result.ok    = 1'b1;
          result.way   = free_way;
          result.wr_en = 1'b1;
          row_next.slots[free_way] = new_slot;
        end else if (fill < FILL_W'(WAYS)) begin
          result.ok    = 1'b1;
          result.way   = WAY_W'(fill);
          result.wr_en = 1'b1;
          row_next.slots[WAY_W'(fill)] = new_slot;
          row_next.fill = fill + FILL_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (exact_hit) begin
          result.ok    = 1'b1;
          result.way   = exact_way;
          result.wr_en = 1'b1;
          row_next.slots[exact_way] = '0;
        end
      end
      CMD_CHECK: begin
        if (check_hit && address != '0) begin
          result.ok      = 1'b1;
          result.way     = check_way;
          result.handler = row.slots[check_way].hnd;
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

endmodule
